// ===== design/frls_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package frls_pkg;

    localparam int NUM_SLOTS       = 64;
    localparam int SLOT_W          = $clog2(NUM_SLOTS);
    localparam int CNT_W           = SLOT_W + 1;
    localparam int MAX_VALUE_BYTES = 8;
    localparam int VAL_W           = 64;
    localparam int TAG_W           = 16;
    localparam int WORD_W          = VAL_W + TAG_W;
    localparam int HDR_W           = 19;
    localparam logic [7:0] ERASED_BYTE = 8'hff;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_HDR_BAD  = 2'd1;
    localparam logic [1:0] ST_FAIL     = 2'd2;

    localparam logic [1:0] REG_VALUE_BYTES = 2'd0;
    localparam logic [1:0] REG_END_MARKER  = 2'd1;
    localparam logic [1:0] REG_SLOTS       = 2'd2;
    localparam logic [1:0] REG_RETRY       = 2'd3;

    localparam logic REQ_STORE = 1'b0;

    typedef struct packed {
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        logic              clr;
    } mem_req_t;

    // value bytes clamped to 1..8
    function automatic logic [3:0] eff_bytes(input logic [3:0] b);
        logic [3:0] r;
        r = b;
        if (b == 4'd0) r = 4'd1;
        if (b > 4'(MAX_VALUE_BYTES)) r = 4'(MAX_VALUE_BYTES);
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] eff_slots(input logic [6:0] n);
        logic [CNT_W-1:0] r;
        r = CNT_W'(n);
        if (n == 7'd0) r = CNT_W'(1);
        if (32'(n) > NUM_SLOTS) r = CNT_W'(NUM_SLOTS);
        return r;
    endfunction

    function automatic logic [VAL_W-1:0] byte_mask(input logic [3:0] b);
        logic [VAL_W-1:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            if (i < 32'(b)) m[i*8 +: 8] = 8'hff;
        end
        return m;
    endfunction

    function automatic logic [7:0] byte_sum(input logic [VAL_W-1:0] v, input logic [3:0] b);
        logic [7:0] s;
        s = 8'd0;
        for (int i = 0; i < 8; i++) begin
            if (i < 32'(b)) s = s + v[i*8 +: 8];
        end
        return s;
    endfunction

endpackage
`default_nettype wire

// ===== design/frls_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
module frls_mem (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire frls_pkg::mem_req_t           req,
    input  wire logic [frls_pkg::WORD_W-1:0]  wr_data,
    output logic      [frls_pkg::WORD_W-1:0]  rd_data
);

    logic [frls_pkg::WORD_W-1:0]    mem [frls_pkg::NUM_SLOTS];
    logic [frls_pkg::NUM_SLOTS-1:0] valid_reg;
    logic [frls_pkg::WORD_W-1:0]    data_reg;
    logic                           hit_reg;

    always_ff @(posedge clk) begin
        if (req.wr_en) mem[req.wr_addr] <= wr_data;
        if (req.rd_en) data_reg <= mem[req.rd_addr];
    end

    // entries never written since the last erase read as erased
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end else begin
            if (req.clr) valid_reg <= '0;
            else if (req.wr_en) valid_reg[req.wr_addr] <= 1'b1;
            if (req.rd_en) hit_reg <= valid_reg[req.rd_addr];
        end
    end

    assign rd_data = hit_reg ? data_reg : '1;

endmodule
`default_nettype wire

// ===== design/flash_record_log_store_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// One request at a time; busy stays high until the result beat.
// Store: scan for an erased slot (read, check), erase if needed, write attempts (read, write).
// Read: scan for the first erased slot (read, check), then walk back (read, check).
// Each step waits on the registered read of the record memory.
// Reset: sector erased, no cached slot, registers at defaults; no clearing pass.
// Results cannot be stalled: done pulses for one cycle with the result fields.
module flash_record_log_store_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        req_type,
    input  wire logic [63:0] new_value,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    output logic             done,
    output logic [1:0]       status,
    output logic [63:0]      read_value,
    output logic [5:0]       slot_used,
    output logic             was_erased
);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_SCAN_CHK, S_INIT, S_ATT, S_ATT_CHK, S_WALK, S_WALK_CHK
    } state_t;

    localparam int SW = frls_pkg::SLOT_W;
    localparam int CW = frls_pkg::CNT_W;

    logic [3:0] vb_reg;
    logic [7:0] end_reg;
    logic [6:0] slots_reg;
    logic [7:0] retry_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vb_reg    <= 4'd8;
            end_reg   <= 8'd0;
            slots_reg <= 7'd64;
            retry_reg <= 8'd0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                frls_pkg::REG_VALUE_BYTES: vb_reg    <= cfg_data[3:0];
                frls_pkg::REG_END_MARKER:  end_reg   <= cfg_data;
                frls_pkg::REG_SLOTS:       slots_reg <= cfg_data[6:0];
                frls_pkg::REG_RETRY:       retry_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    state_t                          state_reg;
    logic                            op_reg;
    logic [63:0]                     val_reg;
    logic [CW-1:0]                   idx_reg;
    logic [7:0]                      att_reg;
    logic                            erased_reg;
    logic [frls_pkg::HDR_W-1:0]      hdr_reg;
    logic [SW-1:0]                   cached_reg;
    logic                            cvalid_reg;
    logic                            done_reg;
    logic [1:0]                      status_reg;
    logic [63:0]                     rval_reg;
    logic [5:0]                      slot_reg;
    logic                            werased_reg;

    logic [3:0]                      eb;
    logic [CW-1:0]                   en;
    logic [63:0]                     m;
    logic [7:0]                      vsum;
    logic [frls_pkg::HDR_W-1:0]      cfg_hdr;
    logic [frls_pkg::WORD_W-1:0]     rd_word;
    logic [frls_pkg::WORD_W-1:0]     wr_word;
    logic [63:0]                     rv;
    logic [15:0]                     rt;
    logic [CW:0]                     idx_inc;
    logic [CW:0]                     cached_inc;
    logic [8:0]                      att_inc;
    logic                            verify_ok;
    logic                            walk_ok;
    logic [CW-1:0]                   scan_pos;
    frls_pkg::mem_req_t              mreq;

    assign eb         = frls_pkg::eff_bytes(vb_reg);
    assign en         = frls_pkg::eff_slots(slots_reg);
    assign m          = frls_pkg::byte_mask(eb);
    assign vsum       = frls_pkg::byte_sum(val_reg, eb);
    assign cfg_hdr    = {slots_reg, vb_reg, end_reg};
    assign wr_word    = rd_word & {val_reg | ~m, vsum, end_reg};
    assign rv         = rd_word[frls_pkg::WORD_W-1:frls_pkg::TAG_W];
    assign rt         = rd_word[frls_pkg::TAG_W-1:0];
    assign idx_inc    = {1'b0, idx_reg} + 1'b1;
    assign cached_inc = (CW+1)'(cached_reg) + 1'b1;
    assign att_inc    = {1'b0, att_reg} + 1'b1;
    assign verify_ok  = ((wr_word[79:16] & m) == (val_reg & m)) &&
                        (wr_word[15:8] == vsum) && (wr_word[7:0] == end_reg);
    assign walk_ok    = (frls_pkg::byte_sum(rv, eb) == rt[15:8]) && (rt[7:0] == end_reg);
    // first erased slot, or the slot count when the scan ran off the end
    assign scan_pos   = (rt[7:0] == frls_pkg::ERASED_BYTE) ? idx_reg : en;

    always_comb begin
        mreq         = '0;
        mreq.rd_addr = idx_reg[SW-1:0];
        mreq.wr_addr = idx_reg[SW-1:0];
        mreq.rd_en   = (state_reg == S_SCAN) || (state_reg == S_WALK) ||
                       (state_reg == S_ATT && !(retry_reg != 8'd0 &&
                                               att_inc > {1'b0, retry_reg}));
        mreq.wr_en   = (state_reg == S_ATT_CHK);
        mreq.clr     = (state_reg == S_INIT);
    end

    frls_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mreq),
        .wr_data (wr_word),
        .rd_data (rd_word)
    );

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg   <= S_IDLE;
            op_reg      <= 1'b0;
            val_reg     <= '0;
            idx_reg     <= '0;
            att_reg     <= '0;
            erased_reg  <= 1'b0;
            hdr_reg     <= '1;
            cached_reg  <= '0;
            cvalid_reg  <= 1'b0;
            done_reg    <= 1'b0;
            status_reg  <= '0;
            rval_reg    <= '0;
            slot_reg    <= '0;
            werased_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (start) begin
                        op_reg     <= req_type;
                        val_reg    <= new_value;
                        att_reg    <= '0;
                        erased_reg <= 1'b0;
                        if (req_type == frls_pkg::REQ_STORE) begin
                            if (cvalid_reg) begin
                                idx_reg   <= cached_inc[CW-1:0];
                                state_reg <= (cached_inc >= {1'b0, en}) ? S_INIT : S_ATT;
                            end else if (hdr_reg != cfg_hdr) begin
                                state_reg <= S_INIT;
                            end else begin
                                idx_reg   <= '0;
                                state_reg <= S_SCAN;
                            end
                        end else begin
                            if (cvalid_reg && CW'(cached_reg) < en) begin
                                idx_reg   <= CW'(cached_reg);
                                state_reg <= S_WALK;
                            end else if (hdr_reg != cfg_hdr) begin
                                done_reg    <= 1'b1;
                                status_reg  <= frls_pkg::ST_HDR_BAD;
                                rval_reg    <= '0;
                                slot_reg    <= '0;
                                werased_reg <= 1'b0;
                            end else begin
                                idx_reg   <= '0;
                                state_reg <= S_SCAN;
                            end
                        end
                    end
                end
                S_SCAN: state_reg <= S_SCAN_CHK;
                S_SCAN_CHK: begin
                    if (rt[7:0] != frls_pkg::ERASED_BYTE && idx_inc < {1'b0, en}) begin
                        idx_reg   <= idx_inc[CW-1:0];
                        state_reg <= S_SCAN;
                    end else if (op_reg == frls_pkg::REQ_STORE) begin
                        idx_reg   <= scan_pos;
                        state_reg <= (scan_pos == en) ? S_INIT : S_ATT;
                    end else if (scan_pos == '0) begin
                        done_reg    <= 1'b1;
                        status_reg  <= frls_pkg::ST_FAIL;
                        rval_reg    <= '0;
                        slot_reg    <= '0;
                        werased_reg <= 1'b0;
                        state_reg   <= S_IDLE;
                    end else begin
                        idx_reg   <= scan_pos - 1'b1;
                        state_reg <= S_WALK;
                    end
                end
                S_INIT: begin
                    hdr_reg    <= cfg_hdr;
                    erased_reg <= 1'b1;
                    idx_reg    <= '0;
                    state_reg  <= S_ATT;
                end
                S_ATT: begin
                    if (retry_reg != 8'd0 && att_inc > {1'b0, retry_reg}) begin
                        done_reg    <= 1'b1;
                        status_reg  <= frls_pkg::ST_FAIL;
                        rval_reg    <= '0;
                        slot_reg    <= 6'(idx_reg);
                        werased_reg <= erased_reg;
                        state_reg   <= S_IDLE;
                    end else begin
                        att_reg   <= att_inc[7:0];
                        state_reg <= S_ATT_CHK;
                    end
                end
                S_ATT_CHK: begin
                    if (verify_ok) begin
                        cached_reg  <= idx_reg[SW-1:0];
                        cvalid_reg  <= 1'b1;
                        done_reg    <= 1'b1;
                        status_reg  <= frls_pkg::ST_OK;
                        rval_reg    <= '0;
                        slot_reg    <= 6'(idx_reg);
                        werased_reg <= erased_reg;
                        state_reg   <= S_IDLE;
                    end else if (idx_inc >= {1'b0, en}) begin
                        state_reg <= S_INIT;
                    end else begin
                        idx_reg   <= idx_inc[CW-1:0];
                        state_reg <= S_ATT;
                    end
                end
                S_WALK: state_reg <= S_WALK_CHK;
                S_WALK_CHK: begin
                    if (walk_ok) begin
                        cached_reg  <= idx_reg[SW-1:0];
                        cvalid_reg  <= 1'b1;
                        done_reg    <= 1'b1;
                        status_reg  <= frls_pkg::ST_OK;
                        rval_reg    <= rv & m;
                        slot_reg    <= 6'(idx_reg);
                        werased_reg <= 1'b0;
                        state_reg   <= S_IDLE;
                    end else if (idx_reg == '0) begin
                        done_reg    <= 1'b1;
                        status_reg  <= frls_pkg::ST_FAIL;
                        rval_reg    <= '0;
                        slot_reg    <= '0;
                        werased_reg <= 1'b0;
                        state_reg   <= S_IDLE;
                    end else begin
                        idx_reg   <= idx_reg - 1'b1;
                        state_reg <= S_WALK;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign status     = status_reg;
    assign read_value = rval_reg;
    assign slot_used  = slot_reg;
    assign was_erased = werased_reg;

endmodule
`default_nettype wire

// ===== design/frls_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module frls_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       done,
    input wire logic [1:0] status,
    input wire logic       was_erased
);

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("result beat while busy");

    // a read that fails the header check answers from idle without going busy
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy || done) else $error("accepted request did not go busy");

    a_done_gap: assert property (@(posedge clk) disable iff (!rst_n)
        done && !(start && !busy) |=> !done) else $error("result beat with no request");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> status != 2'd3) else $error("undefined status code");

    a_erase_store: assert property (@(posedge clk) disable iff (!rst_n)
        done && was_erased |-> status != frls_pkg::ST_HDR_BAD)
        else $error("erase flagged on a read result");

endmodule

bind flash_record_log_store_core frls_checker u_frls_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .status     (status),
    .was_erased (was_erased)
);
`default_nettype wire

// ===== verif/frls_log_checker.sv =====
`timescale 1ns / 1ps
module frls_log_checker
    import frls_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        req_type,
    input  logic [63:0] new_value,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        done,
    input  logic [1:0]  status,
    input  logic [63:0] read_value,
    input  logic [5:0]  slot_used,
    input  logic        was_erased,
    output int          errors,
    output int          pending
);

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] value;
        logic [5:0]  slot;
        logic        erased;
    } log_result_t;

    log_result_t expected_q[$];

    // shadow of the sector and the config registers
    logic [63:0] slot_val[NUM_SLOTS];
    logic [15:0] slot_tag[NUM_SLOTS];
    logic [18:0] sect_hdr;
    int          last_slot;
    bit          last_known;
    logic [3:0]  vbytes;
    logic [7:0]  end_mark;
    logic [6:0]  nslots_raw;
    logic [7:0]  max_tries;

    function automatic int used_bytes();
        int b;
        b = vbytes;
        if (b < 1) b = 1;
        if (b > MAX_VALUE_BYTES) b = MAX_VALUE_BYTES;
        return b;
    endfunction

    function automatic int used_slots();
        int n;
        n = nslots_raw;
        if (n < 1) n = 1;
        if (n > NUM_SLOTS) n = NUM_SLOTS;
        return n;
    endfunction

    function automatic logic [63:0] bytes_mask(int b);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < b; i++) m[i*8 +: 8] = 8'hff;
        return m;
    endfunction

    function automatic logic [7:0] sum_bytes(logic [63:0] v, int b);
        logic [7:0] s;
        s = 8'd0;
        for (int i = 0; i < b; i++) s = s + v[i*8 +: 8];
        return s;
    endfunction

    function automatic logic [18:0] hdr_from_regs();
        return {nslots_raw, vbytes, end_mark};
    endfunction

    function automatic void wipe_sector();
        for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_val[i] = '1;
            slot_tag[i] = '1;
        end
        sect_hdr = '1;
    endfunction

    function automatic int first_free(int n);
        int s;
        s = 0;
        while (s < n && slot_tag[s][7:0] != ERASED_BYTE) s++;
        return s;
    endfunction

    function automatic log_result_t append_record(logic [63:0] v);
        log_result_t r;
        int          b;
        int          n;
        int          slot;
        int          tries;
        logic [63:0] m;
        logic [7:0]  s;
        logic [15:0] tag;
        bit          wipe;
        b = used_bytes();
        n = used_slots();
        m = bytes_mask(b);
        s = sum_bytes(v, b);
        tag = {s, end_mark};
        r = '0;
        wipe = 0;
        slot = 0;
        tries = 0;
        if (last_known) begin
            slot = last_slot + 1;
            wipe = (slot >= n);
        end else if (sect_hdr != hdr_from_regs()) begin
            wipe = 1;
        end else begin
            slot = first_free(n);
            wipe = (slot >= n);
        end
        while (1) begin
            if (wipe) begin
                wipe_sector();
                sect_hdr = hdr_from_regs();
                r.erased = 1'b1;
                slot = 0;
                wipe = 0;
            end
            tries++;
            if (max_tries != 0 && tries > max_tries) begin
                r.status = ST_FAIL;
                r.slot = slot[5:0];
                break;
            end
            slot_val[slot] &= (v | ~m);
            slot_tag[slot] &= tag;
            if ((slot_val[slot] & m) == (v & m) && slot_tag[slot] == tag) begin
                last_slot = slot;
                last_known = 1;
                r.status = ST_OK;
                r.slot = slot[5:0];
                break;
            end
            slot++;
            if (slot >= n) wipe = 1;
        end
        return r;
    endfunction

    function automatic log_result_t fetch_newest();
        log_result_t r;
        int          b;
        int          n;
        int          k;
        int          s;
        b = used_bytes();
        n = used_slots();
        r = '0;
        r.status = ST_FAIL;
        if (last_known && last_slot < n) begin
            k = last_slot;
        end else begin
            if (sect_hdr != hdr_from_regs()) begin
                r.status = ST_HDR_BAD;
                return r;
            end
            s = first_free(n);
            if (s == 0) return r;
            k = s - 1;
        end
        while (1) begin
            if (sum_bytes(slot_val[k], b) == slot_tag[k][15:8] &&
                slot_tag[k][7:0] == end_mark) begin
                last_slot = k;
                last_known = 1;
                r.status = ST_OK;
                r.value = slot_val[k] & bytes_mask(b);
                r.slot = k[5:0];
                return r;
            end
            if (k == 0) return r;
            k--;
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        log_result_t got;
        log_result_t want;
        if (!rst_n) begin
            wipe_sector();
            last_slot = 0;
            last_known = 0;
            vbytes = 4'd8;
            end_mark = 8'd0;
            nslots_raw = 7'd64;
            max_tries = 8'd0;
            errors = 0;
            expected_q.delete();
            pending = 0;
        end else begin
            if (done) begin
                got = {status, read_value, slot_used, was_erased};
                if (expected_q.size() == 0) begin
                    errors++;
                    $display("%0t: result beat with nothing expected: %p", $time, got);
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want) begin
                        errors++;
                        $display("%0t: mismatch expected st=%0d val=%h slot=%0d er=%0d",
                                 $time, want.status, want.value, want.slot, want.erased);
                        $display("%0t:          actual   st=%0d val=%h slot=%0d er=%0d",
                                 $time, got.status, got.value, got.slot, got.erased);
                    end
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_VALUE_BYTES: vbytes = cfg_data[3:0];
                    REG_END_MARKER:  end_mark = cfg_data;
                    REG_SLOTS:       nslots_raw = cfg_data[6:0];
                    REG_RETRY:       max_tries = cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy) begin
                if (req_type == REQ_STORE) expected_q.push_back(append_record(new_value));
                else expected_q.push_back(fetch_newest());
            end
            pending = expected_q.size();
        end
    end

endmodule

// ===== verif/tb_flash_record_log_store_core.sv =====
`timescale 1ns / 1ps
module tb_flash_record_log_store_core;
    import frls_pkg::*;

    localparam int NPHASE = 10;
    localparam int CYCLE_LIMIT = 2_000_000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        req_type;
    logic [63:0] new_value;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;
    logic        done;
    logic [1:0]  status;
    logic [63:0] read_value;
    logic [5:0]  slot_used;
    logic        was_erased;
    int          errors;
    int          pending;
    int          cycles;
    bit          allow_idle;

    // per phase: value bytes, end byte, slot count, retry limit
    logic [7:0] ph_bytes[NPHASE] = '{8, 1, 0, 15, 4, 8, 3, 8, 2, 5};
    logic [7:0] ph_end[NPHASE]   = '{0, 8'ha5, 8'hff, 8'h00, 8'h5a, 8'hfe, 8'h0f, 8'h33,
                                     8'hc3, 8'h81};
    logic [7:0] ph_slots[NPHASE] = '{64, 4, 3, 127, 2, 1, 0, 64, 8, 16};
    logic [7:0] ph_retry[NPHASE] = '{0, 0, 2, 1, 0, 3, 0, 255, 0, 0};

    flash_record_log_store_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req_type   (req_type),
        .new_value  (new_value),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .done       (done),
        .status     (status),
        .read_value (read_value),
        .slot_used  (slot_used),
        .was_erased (was_erased)
    );

    frls_log_checker chk (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // leaves start high after the accepting edge, except on a random idle where it lowers start itself
    task automatic issue(input logic kind, input logic [63:0] v);
        logic was_busy;
        start <= 1'b1;
        req_type <= kind;
        new_value <= v;
        while (1)
        begin
            @(negedge clk);
            was_busy = busy;
            @(posedge clk);
            if (!was_busy) break;
        end
        if (allow_idle && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [7:0] d);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
    endtask

    function automatic logic [63:0] rand_value();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        req_type = REQ_STORE;
        new_value = '0;
        cfg_we = 1'b0;
        cfg_index = REG_VALUE_BYTES;
        cfg_data = '0;
        cycles = 0;
        allow_idle = 1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: read before any store sees the erased header
        issue(~REQ_STORE, '0);
        issue(REQ_STORE, '0);
        issue(REQ_STORE, '1);
        issue(REQ_STORE, 64'h0123_4567_89ab_cdef);
        issue(~REQ_STORE, '0);
        issue(REQ_STORE, 64'h8000_0000_0000_0001);
        issue(~REQ_STORE, '0);
        issue(REQ_STORE, 64'hfedc_ba98_7654_3210);
        drain();
        // shrink the sector below the cached slot: header check on read, erase on store
        reg_write(REG_SLOTS, 8'd2);
        reg_write(REG_RETRY, 8'd1);
        cfg_we <= 1'b0;
        issue(~REQ_STORE, '0);
        issue(REQ_STORE, 64'h55);
        issue(REQ_STORE, 64'haa);
        issue(REQ_STORE, 64'h0f);
        issue(~REQ_STORE, '0);
        issue(REQ_STORE, '1);
        issue(~REQ_STORE, '0);

        for (int p = 0; p < NPHASE; p++)
        begin
            drain();
            reg_write(REG_VALUE_BYTES, ph_bytes[p]);
            reg_write(REG_END_MARKER, ph_end[p]);
            reg_write(REG_SLOTS, ph_slots[p]);
            reg_write(REG_RETRY, ph_retry[p]);
            cfg_we <= 1'b0;
            allow_idle = (p != NPHASE - 1);
            for (int i = 0; i < 110; i++)
            begin
                if ($urandom_range(0, 9) < 6) issue(REQ_STORE, rand_value());
                else issue(~REQ_STORE, rand_value());
            end
        end
        drain();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
